FILE: design/hbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbt_pkg: shared types and constants of the heartbeat membership table
// Slot record, status, function and outcome codes, field widths.
// ----------------------------------------------------------------------------
package hbt_pkg;

  localparam int MAX_MEMBERS_DEF = 32;
  localparam int ADDR_W          = 48;
  localparam int HB_W            = 32;
  localparam int TM_W            = 32;
  localparam int TO_W            = 16;
  localparam int ENTRY_W         = 33;
  localparam int MEMB_W          = 6;
  localparam int CFG_IDX_W       = 2;

  localparam logic [TO_W-1:0] FAIL_TIMEOUT_RST    = TO_W'(50);
  localparam logic [TO_W-1:0] CLEANUP_TIMEOUT_RST = TO_W'(80);

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_FAILED  = 2'd1,
    ST_REMOVED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FN_GOSSIP = 2'd0,
    FN_TICK   = 2'd1,
    FN_DUMP   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    OC_SELF     = 3'd0,
    OC_NULL     = 3'd1,
    OC_UPDATED  = 3'd2,
    OC_STALE    = 3'd3,
    OC_INSERTED = 3'd4,
    OC_FULL     = 3'd5,
    OC_TICK     = 3'd6,
    OC_DUMP     = 3'd7
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELF_ADDRESS    = 2'd0,
    CFG_FAIL_TIMEOUT    = 2'd1,
    CFG_CLEANUP_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [HB_W-1:0]   hb;
    logic [TM_W-1:0]   tm;
    status_t           st;
  } slot_t;

endpackage
`default_nettype wire

FILE: design/hbt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbt_in_if / hbt_out_if: item channels of the membership table
// Valid/ready channels carrying gossip, tick and dump requests and results.
// ----------------------------------------------------------------------------
interface hbt_in_if;
  import hbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [ADDR_W-1:0] peer_address;
  logic [HB_W-1:0]   peer_heartbeat;
  logic [TM_W-1:0]   peer_time;
  logic [TM_W-1:0]   now;
  logic              message_end;

  modport source (output valid, func, peer_address, peer_heartbeat, peer_time, now,
                  message_end, input ready);
  modport sink   (input valid, func, peer_address, peer_heartbeat, peer_time, now,
                  message_end, output ready);
endinterface

interface hbt_out_if;
  import hbt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [2:0]                outcome;
  logic [ADDR_W-1:0]         entry_address;
  logic signed [ENTRY_W-1:0] entry_heartbeat;
  logic signed [ENTRY_W-1:0] entry_time;
  logic                      entry_empty;
  logic [MEMB_W-1:0]         members;
  logic                      last;

  modport source (output valid, outcome, entry_address, entry_heartbeat, entry_time,
                  entry_empty, members, last, input ready);
  modport sink   (input valid, outcome, entry_address, entry_heartbeat, entry_time,
                  entry_empty, members, last, output ready);
endinterface
`default_nettype wire

FILE: design/hbt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbt_cell: one slot of the rotating membership ring
// Holds one slot record and takes its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module hbt_cell (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire hbt_pkg::slot_t slot_d,
  output      hbt_pkg::slot_t slot_q
);
  import hbt_pkg::*;

  slot_t slot_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      slot_r <= slot_d;
    end
  end

  assign slot_q = slot_r;

endmodule
`default_nettype wire

FILE: design/heartbeat_membership_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heartbeat_membership_table_unit: gossip heartbeat membership table
// Slots rotate through a ring of cells past one head that merges, ages or
// dumps the slot in front of it; one full turn handles one item.
// Gossip and tick: the result is loaded in the done state after the full turn,
//   then the next item is taken; a self or null address skips the turn.
// Dump: one result per shift for each slot below the member count, each shift
//   held while the result channel stalls; an empty table gives no result.
// Reset clears the member count and loads the register defaults; slot
//   contents are not cleared, only slots below the member count are read.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_unit #(
  parameter int MAX_MEMBERS = hbt_pkg::MAX_MEMBERS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hbt_in_if.sink                               in_ch,
  hbt_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [hbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hbt_pkg::ADDR_W-1:0]      cfg_data
);
  import hbt_pkg::*;

  localparam int CW = $clog2(MAX_MEMBERS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t            state_r;
  func_t             op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [HB_W-1:0]   hb_r;
  logic [TM_W-1:0]   tm_r;
  logic [TM_W-1:0]   now_r;
  logic [CW-1:0]     k_r;
  logic [CW-1:0]     count_r;
  logic              found_r;
  outcome_t          oc_r;

  logic [ADDR_W-1:0] self_addr_r;
  logic [TO_W-1:0]   fail_to_r;
  logic [TO_W-1:0]   clean_to_r;

  logic                      out_valid_r;
  outcome_t                  out_oc_r;
  logic [ADDR_W-1:0]         out_addr_r;
  logic signed [ENTRY_W-1:0] out_hb_r;
  logic signed [ENTRY_W-1:0] out_tm_r;
  logic                      out_empty_r;
  logic [MEMB_W-1:0]         out_memb_r;
  logic                      out_last_r;

  slot_t cell_q [MAX_MEMBERS];
  slot_t cell_d [MAX_MEMBERS];
  slot_t cur;
  slot_t head;

  logic          shift_en;
  logic          out_free;
  logic          out_load;
  logic          active;
  logic          found_nxt;
  outcome_t      oc_nxt;
  logic [CW-1:0] count_nxt;
  logic [TM_W:0] age;
  logic          age_pos;
  logic          last_step;

  // ring: cell i takes from cell i+1, the head writes back into the far end
  for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_cell
    if (i == MAX_MEMBERS - 1) begin : g_end
      assign cell_d[i] = head;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    hbt_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .slot_d   (cell_d[i]),
      .slot_q   (cell_q[i])
    );
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign shift_en  = (state_r == S_SCAN) && ((op_r != FN_DUMP) || out_free);
  assign out_load  = (shift_en && op_r == FN_DUMP && active) ||
                     (state_r == S_DONE && out_free);
  assign cur       = cell_q[0];
  assign active    = k_r < count_r;
  assign last_step = k_r == CW'(MAX_MEMBERS - 1);
  assign age       = {1'b0, now_r} - {1'b0, cur.tm};
  assign age_pos   = !age[TM_W];

  always_comb begin
    head      = cur;
    found_nxt = found_r;
    oc_nxt    = oc_r;
    count_nxt = count_r;
    case (op_r)
      FN_GOSSIP: begin
        if (active && !found_r && cur.addr == addr_r) begin
          found_nxt = 1'b1;
          if (cur.hb < hb_r) begin
            head.hb = hb_r;
            head.tm = tm_r;
            oc_nxt  = OC_UPDATED;
          end else begin
            oc_nxt = OC_STALE;
          end
        end else if (k_r == count_r && !found_r) begin
          head.addr = addr_r;
          head.hb   = hb_r;
          head.tm   = tm_r;
          head.st   = ST_NORMAL;
          found_nxt = 1'b1;
          count_nxt = count_r + CW'(1);
          oc_nxt    = OC_INSERTED;
        end
      end
      FN_TICK: begin
        if (active && cur.st != ST_REMOVED) begin
          if (cur.st == ST_FAILED && age_pos && age[TM_W-1:0] > {16'b0, clean_to_r}) begin
            head.st = ST_REMOVED;
          end else if (age_pos && age[TM_W-1:0] > {16'b0, fail_to_r}) begin
            head.st = ST_FAILED;
          end else begin
            head.st = ST_NORMAL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      self_addr_r <= '0;
      fail_to_r   <= FAIL_TIMEOUT_RST;
      clean_to_r  <= CLEANUP_TIMEOUT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SELF_ADDRESS:    self_addr_r <= cfg_data;
          CFG_FAIL_TIMEOUT:    fail_to_r   <= cfg_data[TO_W-1:0];
          CFG_CLEANUP_TIMEOUT: clean_to_r  <= cfg_data[TO_W-1:0];
          default: begin
          end
        endcase
      end

      // drop the taken item unless a new one loads in the same cycle
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= func_t'(in_ch.func);
            addr_r  <= in_ch.peer_address;
            hb_r    <= in_ch.peer_heartbeat;
            tm_r    <= in_ch.peer_time;
            now_r   <= in_ch.now;
            k_r     <= '0;
            found_r <= 1'b0;
            unique case (in_ch.func)
              FN_GOSSIP: begin
                if (in_ch.peer_address == self_addr_r) begin
                  oc_r    <= OC_SELF;
                  state_r <= S_DONE;
                end else if (in_ch.peer_address == '0) begin
                  oc_r    <= OC_NULL;
                  state_r <= S_DONE;
                end else begin
                  oc_r    <= OC_FULL;
                  state_r <= S_SCAN;
                end
              end
              FN_TICK: begin
                oc_r    <= OC_TICK;
                state_r <= S_SCAN;
              end
              FN_DUMP: begin
                oc_r    <= OC_DUMP;
                state_r <= (count_r != '0) ? S_SCAN : S_IDLE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (shift_en) begin
            found_r <= found_nxt;
            oc_r    <= oc_nxt;
            count_r <= count_nxt;
            k_r     <= k_r + CW'(1);
            if (op_r == FN_DUMP && active) begin
              out_valid_r <= 1'b1;
              out_oc_r    <= OC_DUMP;
              out_memb_r  <= MEMB_W'(count_r);
              out_last_r  <= (k_r + CW'(1)) == count_r;
              if (cur.st == ST_NORMAL) begin
                out_addr_r  <= cur.addr;
                out_hb_r    <= {1'b0, cur.hb};
                out_tm_r    <= {1'b0, cur.tm};
                out_empty_r <= 1'b0;
              end else begin
                out_addr_r  <= '0;
                out_hb_r    <= '1;
                out_tm_r    <= '1;
                out_empty_r <= 1'b1;
              end
            end
            if (last_step) begin
              state_r <= (op_r == FN_DUMP) ? S_IDLE : S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_oc_r    <= oc_r;
            out_addr_r  <= '0;
            out_hb_r    <= '0;
            out_tm_r    <= '0;
            out_empty_r <= 1'b0;
            out_memb_r  <= MEMB_W'(count_r);
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.outcome         = out_oc_r;
  assign out_ch.entry_address   = out_addr_r;
  assign out_ch.entry_heartbeat = out_hb_r;
  assign out_ch.entry_time      = out_tm_r;
  assign out_ch.entry_empty     = out_empty_r;
  assign out_ch.members         = out_memb_r;
  assign out_ch.last            = out_last_r;

endmodule
`default_nettype wire
